### hw/rtl/smdp_pkg.sv
// Shared types and constants for the segmentation mask dot-product block.
package smdp_pkg;

  localparam int Lanes    = 8;
  localparam int LaneBits = 3;
  localparam int DataW    = 16;
  localparam int CoefIdxW = 5;
  localparam int PixIdxW  = 15;
  localparam int CfgW     = 8;
  localparam int CfgIdxW  = 3;

  localparam logic [CfgIdxW-1:0] CfgBoxColMin = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgBoxColMax = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgBoxRowMin = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgBoxRowMax = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgFillValue = 3'd4;

  localparam logic [CfgW-1:0] BoxMinRst = 8'd0;
  localparam logic [CfgW-1:0] BoxMaxRst = 8'd160;
  localparam logic [CfgW-1:0] FillRst   = 8'd255;

  localparam logic ReqCoef  = 1'b0;
  localparam logic ReqPixel = 1'b1;

  typedef struct packed {
    logic                    req_type;
    logic [CoefIdxW-1:0]     coef_index;
    logic signed [DataW-1:0] coef_value;
    logic signed [DataW-1:0] proto_lane0;
    logic signed [DataW-1:0] proto_lane1;
    logic signed [DataW-1:0] proto_lane2;
    logic signed [DataW-1:0] proto_lane3;
    logic signed [DataW-1:0] proto_lane4;
    logic signed [DataW-1:0] proto_lane5;
    logic signed [DataW-1:0] proto_lane6;
    logic signed [DataW-1:0] proto_lane7;
  } smdp_in_t;

  typedef struct packed {
    logic [PixIdxW-1:0] pixel_index;
    logic [7:0]         mask_byte;
    logic               in_box;
    logic               map_done;
  } smdp_out_t;

  typedef struct packed {
    logic [CfgW-1:0] box_col_min;
    logic [CfgW-1:0] box_col_max;
    logic [CfgW-1:0] box_row_min;
    logic [CfgW-1:0] box_row_max;
    logic [CfgW-1:0] fill_value;
  } smdp_cfg_t;

  typedef struct packed {
    logic wr_en;
    logic rd_en;
    logic mul_en;
  } smdp_lane_ctl_t;

  typedef struct packed {
    logic take;
    logic last;
  } smdp_beat_ctl_t;

endpackage

### hw/rtl/smdp_lane.sv
// One lane: coefficient bank for its features, operand registers and multiplier.
module smdp_lane import smdp_pkg::*; #(
  parameter int FEATURES = 32,
  parameter int LANE     = 0,
  parameter int BEATS    = (FEATURES + Lanes - 1) / Lanes,
  parameter int BW       = (BEATS > 1) ? $clog2(BEATS) : 1
) (
  input  logic                      clk_i,
  input  smdp_lane_ctl_t            ctl_i,
  input  logic [BW-1:0]             wr_addr_i,
  input  logic signed [DataW-1:0]   wr_data_i,
  input  logic [BW-1:0]             rd_addr_i,
  input  logic signed [DataW-1:0]   proto_i,
  output logic signed [2*DataW-1:0] prod_o
);

  logic signed [DataW-1:0]   bank_q [BEATS];
  logic signed [DataW-1:0]   coef_q;
  logic signed [DataW-1:0]   proto_q;
  logic signed [2*DataW-1:0] prod_q;
  logic                      feat_ok;

  // Features past the end of the vector contribute nothing.
  assign feat_ok = (int'(rd_addr_i) * Lanes + LANE) < FEATURES;

  always_ff @(posedge clk_i) begin
    if (ctl_i.wr_en) begin
      bank_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.rd_en) begin
      coef_q  <= feat_ok ? bank_q[rd_addr_i] : '0;
      proto_q <= proto_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.mul_en) begin
      prod_q <= coef_q * proto_q;
    end
  end

  assign prod_o = prod_q;

endmodule

### hw/rtl/smdp_merge.sv
// Merge stage: lane sum, running dot product, pixel position and output register.
module smdp_merge import smdp_pkg::*; #(
  parameter int MAP_SIZE = 160,
  parameter int FEATURES = 32
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  smdp_beat_ctl_t            beat_i,
  input  logic signed [2*DataW-1:0] prod_i [Lanes],
  input  smdp_cfg_t                 cfg_i,
  output logic                      ready_o,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output smdp_out_t                 out_word_o
);

  localparam int SumW = 2 * DataW + LaneBits;
  localparam int AccW = 2 * DataW + ((FEATURES > 1) ? $clog2(FEATURES) : 1);
  localparam int CW   = (MAP_SIZE > 1) ? $clog2(MAP_SIZE) : 1;
  localparam int XW   = (CW > CfgW) ? CW : CfgW;
  localparam int PW   = $clog2(MAP_SIZE * MAP_SIZE);

  logic signed [SumW-1:0] sum_d, sum_q;
  logic                   v3_q, last3_q;
  logic signed [AccW-1:0] acc_q, total;
  logic [CW-1:0]          col_q, row_q;
  logic [PW-1:0]          pix_q;
  logic                   out_v_q;
  smdp_out_t              out_q;
  logic                   out_rdy, fire3, emit, box_hit, last_col, last_row;

  always_comb begin
    sum_d = '0;
    for (int j = 0; j < Lanes; j++) begin
      sum_d = sum_d + SumW'(prod_i[j]);
    end
  end

  assign out_rdy = !out_v_q || !out_stall_i;
  assign fire3   = v3_q && (!last3_q || out_rdy);
  assign emit    = fire3 && last3_q;
  assign ready_o = !v3_q || fire3;

  assign total    = acc_q + AccW'(sum_q);
  assign last_col = col_q == CW'(MAP_SIZE - 1);
  assign last_row = row_q == CW'(MAP_SIZE - 1);
  assign box_hit  = (XW'(col_q) >= XW'(cfg_i.box_col_min)) &&
                    (XW'(col_q) <= XW'(cfg_i.box_col_max)) &&
                    (XW'(row_q) >= XW'(cfg_i.box_row_min)) &&
                    (XW'(row_q) <= XW'(cfg_i.box_row_max));

  always_ff @(posedge clk_i) begin
    if (beat_i.take) begin
      sum_q <= sum_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q    <= 1'b0;
      last3_q <= 1'b0;
      acc_q   <= '0;
      col_q   <= '0;
      row_q   <= '0;
      pix_q   <= '0;
      out_v_q <= 1'b0;
    end else begin
      if (beat_i.take) begin
        v3_q    <= 1'b1;
        last3_q <= beat_i.last;
      end else if (fire3) begin
        v3_q <= 1'b0;
      end
      if (fire3) begin
        acc_q <= last3_q ? '0 : total;
      end
      if (emit) begin
        col_q <= last_col ? '0 : col_q + 1'b1;
        if (last_col) begin
          row_q <= last_row ? '0 : row_q + 1'b1;
        end
        pix_q <= (last_col && last_row) ? '0 : pix_q + 1'b1;
      end
      if (emit) begin
        out_v_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_v_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_q.pixel_index <= PixIdxW'(pix_q);
      out_q.mask_byte   <= (box_hit && !total[AccW-1]) ? cfg_i.fill_value : '0;
      out_q.in_box      <= box_hit;
      out_q.map_done    <= last_col && last_row;
    end
  end

  assign out_valid_o = out_v_q;
  assign out_word_o  = out_q;

  a_acc_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit |=> (acc_q == '0))
    else $error("accumulator not cleared after a pixel");

  a_mid_beat_flows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v3_q && !last3_q) |-> ready_o)
    else $error("non-final beat held in merge stage");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_v_q && out_stall_i) |-> !emit)
    else $error("result emitted over a stalled word");

  a_done_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_v_q && out_q.map_done) |->
      (out_q.pixel_index == PixIdxW'(MAP_SIZE * MAP_SIZE - 1)))
    else $error("map end flagged on wrong pixel");

endmodule

### hw/rtl/seg_mask_dot_product_threshold.sv
// Top level: instance mask assembly from prototype beats and mask coefficients.
// Result: a pixel's result word is registered after its last beat passes the operand, product and lane-sum registers.
// Throughput: one input word per cycle while in_stall_o is low; one result per ceil(FEATURES/8) pixel beats.
// Stall: input stalls only when both lane stages are full and the merge stage is blocked.
// Reset: clears pipeline valids, beat/pixel counters and accumulator; sets box/fill registers to their defaults.
// Reset leaves the coefficient banks unset; load all coefficients before the first pixel.
module seg_mask_dot_product_threshold import smdp_pkg::*; #(
  parameter int MAP_SIZE = 160,
  parameter int FEATURES = 32
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  smdp_in_t             in_word_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output smdp_out_t            out_word_o,
  input  logic                 cfg_we_i,
  input  logic [CfgIdxW-1:0]   cfg_index_i,
  input  logic [CfgW-1:0]      cfg_wdata_i
);

  localparam int BEATS = (FEATURES + Lanes - 1) / Lanes;
  localparam int BW    = (BEATS > 1) ? $clog2(BEATS) : 1;

  // Configuration registers.
  smdp_cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.box_col_min <= BoxMinRst;
      cfg_q.box_col_max <= BoxMaxRst;
      cfg_q.box_row_min <= BoxMinRst;
      cfg_q.box_row_max <= BoxMaxRst;
      cfg_q.fill_value  <= FillRst;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CfgBoxColMin: cfg_q.box_col_min <= cfg_wdata_i;
        CfgBoxColMax: cfg_q.box_col_max <= cfg_wdata_i;
        CfgBoxRowMin: cfg_q.box_row_min <= cfg_wdata_i;
        CfgBoxRowMax: cfg_q.box_row_max <= cfg_wdata_i;
        CfgFillValue: cfg_q.fill_value  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Pipeline: stage 1 holds operands, stage 2 holds products, stage 3 in the merge.
  logic          v1_q, v2_q, last1_q, last2_q;
  logic          rdy1, rdy2, rdy3, fire1;
  logic          accept, accept_coef, accept_beat, beat_last;
  logic [BW-1:0] beat_q;

  assign rdy2  = !v2_q || rdy3;
  assign rdy1  = !v1_q || rdy2;
  assign fire1 = v1_q && rdy2;

  assign in_stall_o  = !rdy1;
  assign accept      = in_valid_i && !in_stall_o;
  assign accept_coef = accept && (in_word_i.req_type == ReqCoef);
  assign accept_beat = accept && (in_word_i.req_type == ReqPixel);
  assign beat_last   = beat_q == BW'(BEATS - 1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q    <= 1'b0;
      v2_q    <= 1'b0;
      last1_q <= 1'b0;
      last2_q <= 1'b0;
      beat_q  <= '0;
    end else begin
      // Advance beat position; the last beat of a pixel wraps back to zero.
      if (accept_beat) begin
        beat_q  <= beat_last ? '0 : beat_q + 1'b1;
        v1_q    <= 1'b1;
        last1_q <= beat_last;
      end else if (fire1) begin
        v1_q <= 1'b0;
      end
      if (fire1) begin
        v2_q    <= 1'b1;
        last2_q <= last1_q;
      end else if (rdy3) begin
        v2_q <= 1'b0;
      end
    end
  end

  // Route coefficient loads: low index bits pick the lane, high bits the beat.
  logic                    coef_in_range;
  logic [BW-1:0]           coef_addr;
  logic signed [DataW-1:0] proto [Lanes];
  logic signed [2*DataW-1:0] prod [Lanes];
  smdp_lane_ctl_t          lane_ctl [Lanes];

  assign coef_in_range = int'(in_word_i.coef_index) < FEATURES;
  assign coef_addr     = BW'(in_word_i.coef_index >> LaneBits);

  assign proto[0] = in_word_i.proto_lane0;
  assign proto[1] = in_word_i.proto_lane1;
  assign proto[2] = in_word_i.proto_lane2;
  assign proto[3] = in_word_i.proto_lane3;
  assign proto[4] = in_word_i.proto_lane4;
  assign proto[5] = in_word_i.proto_lane5;
  assign proto[6] = in_word_i.proto_lane6;
  assign proto[7] = in_word_i.proto_lane7;

  for (genvar j = 0; j < Lanes; j++) begin : g_lane
    assign lane_ctl[j].wr_en  = accept_coef && coef_in_range &&
                                (in_word_i.coef_index[LaneBits-1:0] == LaneBits'(j));
    assign lane_ctl[j].rd_en  = accept_beat;
    assign lane_ctl[j].mul_en = fire1;

    smdp_lane #(
      .FEATURES (FEATURES),
      .LANE     (j),
      .BEATS    (BEATS),
      .BW       (BW)
    ) u_lane (
      .clk_i     (clk_i),
      .ctl_i     (lane_ctl[j]),
      .wr_addr_i (coef_addr),
      .wr_data_i (in_word_i.coef_value),
      .rd_addr_i (beat_q),
      .proto_i   (proto[j]),
      .prod_o    (prod[j])
    );
  end

  // Merge lanes, accumulate, threshold and hold the result word.
  smdp_beat_ctl_t beat_ctl;

  assign beat_ctl.take = v2_q && rdy3;
  assign beat_ctl.last = last2_q;

  smdp_merge #(
    .MAP_SIZE (MAP_SIZE),
    .FEATURES (FEATURES)
  ) u_merge (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .beat_i      (beat_ctl),
    .prod_i      (prod),
    .cfg_i       (cfg_q),
    .ready_o     (rdy3),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o)
  );

  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (v1_q && v2_q && !rdy3))
    else $error("input stalled with room in the pipeline");

endmodule

### bench/seg_mask_dot_product_threshold_tb.sv
`timescale 1ns / 100ps
// Self-checking bench for the segmentation mask dot-product threshold block.
module seg_mask_dot_product_threshold_tb;
  import smdp_pkg::*;

  localparam int MapSize       = 160;
  localparam int FeatureCount  = 32;
  localparam int BeatsPerPixel = (FeatureCount + Lanes - 1) / Lanes;
  localparam int PixelsPerMap  = MapSize * MapSize;
  localparam int SettleCycles  = 8;     // lets results still in the pipeline come out
  localparam int DrainLimit    = 5000;
  localparam int PhaseWords    = 200;
  localparam int FlatPixels    = 60;

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        in_valid_i  = 1'b0;
  logic        in_stall_o;
  smdp_in_t    in_word_i   = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  smdp_out_t   out_word_o;
  logic        cfg_we_i    = 1'b0;
  logic [CfgIdxW-1:0] cfg_index_i = '0;
  logic [CfgW-1:0]    cfg_wdata_i = '0;

  // Random idling on both sides; cleared for the long flat-out stretch.
  bit idle_on = 1'b1;

  seg_mask_dot_product_threshold #(
    .MAP_SIZE(MapSize),
    .FEATURES(FeatureCount)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_word_i  (in_word_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_word_o (out_word_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_index_i(cfg_index_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Mask predictor: mirrors coefficient bank, running dot product, beat and
  // pixel counters and box registers; queues one expected word per pixel.
  class mask_scoreboard;
    logic signed [DataW-1:0] coef_bank [FeatureCount];
    longint                  dot_sum;
    int unsigned             beat_idx;
    int unsigned             pixel_idx;
    smdp_cfg_t               box_cfg;
    smdp_out_t               pending_pixels [$];
    int unsigned             mismatch_count;

    function new();
      foreach (coef_bank[i]) coef_bank[i] = '0;
      dot_sum        = 0;
      beat_idx       = 0;
      pixel_idx      = 0;
      box_cfg        = '{BoxMinRst, BoxMaxRst, BoxMinRst, BoxMaxRst, FillRst};
      mismatch_count = 0;
    endfunction

    function void note_mismatch(string field, logic [31:0] exp_v, logic [31:0] act_v);
      mismatch_count++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, exp_v, act_v);
    endfunction

    // Apply one accepted input word; a pixel's last beat queues its result.
    function void note_word(smdp_in_t w);
      logic signed [DataW-1:0] lane [Lanes];
      smdp_out_t               want;
      int unsigned             row;
      int unsigned             col;
      int unsigned             feat;
      bit                      in_window;
      if (w.req_type == ReqCoef) begin
        if (w.coef_index < FeatureCount) coef_bank[w.coef_index] = w.coef_value;
        return;
      end
      lane = '{w.proto_lane0, w.proto_lane1, w.proto_lane2, w.proto_lane3,
               w.proto_lane4, w.proto_lane5, w.proto_lane6, w.proto_lane7};
      for (int j = 0; j < Lanes; j++) begin
        feat = beat_idx * Lanes + j;
        if (feat < FeatureCount)
          dot_sum += longint'(coef_bank[feat]) * longint'(lane[j]);
      end
      if (beat_idx + 1 < BeatsPerPixel) begin
        beat_idx++;
        return;
      end
      row = pixel_idx / MapSize;
      col = pixel_idx % MapSize;
      in_window = col >= box_cfg.box_col_min && col <= box_cfg.box_col_max &&
                  row >= box_cfg.box_row_min && row <= box_cfg.box_row_max;
      want.pixel_index = pixel_idx[PixIdxW-1:0];
      // A zero sum counts as set: sigmoid(0) sits exactly at one half.
      want.mask_byte   = (in_window && dot_sum >= 0) ? box_cfg.fill_value : 8'd0;
      want.in_box      = in_window;
      want.map_done    = (pixel_idx + 1 >= PixelsPerMap);
      pending_pixels.push_back(want);
      pixel_idx = want.map_done ? 0 : pixel_idx + 1;
      beat_idx  = 0;
      dot_sum   = 0;
    endfunction

    function void check_word(smdp_out_t got);
      smdp_out_t want;
      if (pending_pixels.size() == 0) begin
        mismatch_count++;
        $display("%0t: result word with none expected, actual %0h", $time, got);
        return;
      end
      want = pending_pixels.pop_front();
      if (got.pixel_index !== want.pixel_index)
        note_mismatch("pixel_index", 32'(want.pixel_index), 32'(got.pixel_index));
      if (got.mask_byte !== want.mask_byte)
        note_mismatch("mask_byte", 32'(want.mask_byte), 32'(got.mask_byte));
      if (got.in_box !== want.in_box)
        note_mismatch("in_box", 32'(want.in_box), 32'(got.in_box));
      if (got.map_done !== want.map_done)
        note_mismatch("map_done", 32'(want.map_done), 32'(got.map_done));
    endfunction

    function void flush_leftovers();
      if (pending_pixels.size() != 0) begin
        $display("%0t: %0d expected result words never arrived, next pixel_index %0d",
                 $time, pending_pixels.size(), pending_pixels[0].pixel_index);
        mismatch_count += pending_pixels.size();
        pending_pixels.delete();
      end
    endfunction
  endclass

  mask_scoreboard mask_check;

  // Check results and pick the next receiver stall, both off the same edge.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) mask_check.check_word(out_word_o);
    out_stall_i <= idle_on && ($urandom_range(99) < 30);
  end

  // Bias toward the Q4.12 extremes, zero and small values around zero.
  function automatic logic [DataW-1:0] pick_value();
    logic [DataW-1:0] v;
    case ($urandom_range(7))
      0: v = 16'h8000;
      1: v = 16'h7FFF;
      2: v = '0;
      3: begin
        v = DataW'($urandom_range(255));
        v = v - 16'd128;
      end
      default: v = DataW'($urandom);
    endcase
    return v;
  endfunction

  function automatic smdp_in_t noise_word();
    smdp_in_t w;
    w.req_type    = 1'($urandom_range(1));
    w.coef_index  = CoefIdxW'($urandom_range(FeatureCount - 1));
    w.coef_value  = pick_value();
    w.proto_lane0 = pick_value();
    w.proto_lane1 = pick_value();
    w.proto_lane2 = pick_value();
    w.proto_lane3 = pick_value();
    w.proto_lane4 = pick_value();
    w.proto_lane5 = pick_value();
    w.proto_lane6 = pick_value();
    w.proto_lane7 = pick_value();
    return w;
  endfunction

  function automatic smdp_in_t coef_word(input logic [CoefIdxW-1:0] idx,
                                         input logic [DataW-1:0] value);
    smdp_in_t w;
    w            = noise_word();
    w.req_type   = ReqCoef;
    w.coef_index = idx;
    w.coef_value = value;
    return w;
  endfunction

  function automatic smdp_in_t rand_beat();
    smdp_in_t w;
    w          = noise_word();
    w.req_type = ReqPixel;
    return w;
  endfunction

  // One beat with every lane carrying the same value.
  function automatic smdp_in_t beat_word(input logic [DataW-1:0] value);
    smdp_in_t w;
    w             = rand_beat();
    w.proto_lane0 = value;
    w.proto_lane1 = value;
    w.proto_lane2 = value;
    w.proto_lane3 = value;
    w.proto_lane4 = value;
    w.proto_lane5 = value;
    w.proto_lane6 = value;
    w.proto_lane7 = value;
    return w;
  endfunction

  // Offer one word and hold it until the block takes it. Valid stays high
  // into the next word so back-to-back words need no extra NBA.
  task automatic send_word(input smdp_in_t w);
    while (idle_on && $urandom_range(99) < 30) begin
      in_valid_i <= 1'b0;
      in_word_i  <= noise_word();
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_word_i  <= w;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    mask_check.note_word(w);
  endtask

  task automatic send_pixel(input logic [DataW-1:0] value);
    repeat (BeatsPerPixel) send_word(beat_word(value));
  endtask

  // Random pixel, with the odd coefficient reload slipped between its beats.
  task automatic send_random_pixel();
    repeat (BeatsPerPixel) begin
      if ($urandom_range(99) < 3)
        send_word(coef_word(CoefIdxW'($urandom_range(FeatureCount - 1)), pick_value()));
      send_word(rand_beat());
    end
  endtask

  // Drop valid, wait out every queued result, then let the pipe settle.
  task automatic wait_for_results();
    int unsigned waited;
    in_valid_i <= 1'b0;
    waited = 0;
    while (mask_check.pending_pixels.size() != 0 && waited < DrainLimit) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgW-1:0] value);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= value;
    @(posedge clk_i);
  endtask

  // Program all box and fill registers; call only with the block idle and
  // on a pixel boundary.
  task automatic program_box(input logic [CfgW-1:0] col_lo, input logic [CfgW-1:0] col_hi,
                             input logic [CfgW-1:0] row_lo, input logic [CfgW-1:0] row_hi,
                             input logic [CfgW-1:0] fill);
    write_reg(CfgBoxColMin, col_lo);
    write_reg(CfgBoxColMax, col_hi);
    write_reg(CfgBoxRowMin, row_lo);
    write_reg(CfgBoxRowMax, row_hi);
    write_reg(CfgFillValue, fill);
    cfg_we_i <= 1'b0;
    mask_check.box_cfg = '{col_lo, col_hi, row_lo, row_hi, fill};
  endtask

  // Mostly pixel beats, some coefficient reloads anywhere in a pixel; finish
  // on a pixel boundary. Optionally pause mid-phase until all results are in.
  task automatic run_random(input int count, input int pause_at);
    for (int i = 0; i < count; i++) begin
      if (i == pause_at) wait_for_results();
      if ($urandom_range(99) < 12)
        send_word(coef_word(CoefIdxW'($urandom_range(FeatureCount - 1)), pick_value()));
      else
        send_word(rand_beat());
    end
    while (mask_check.beat_idx != 0) send_word(rand_beat());
    wait_for_results();
  endtask

  initial begin : stimulus
    mask_check = new();
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Fill the whole coefficient bank before any pixel; reset leaves it unset.
    for (int i = 0; i < FeatureCount; i++) send_word(coef_word(CoefIdxW'(i), 16'h8000));

    // Directed part under reset box and fill values.
    send_pixel(16'h8000);                   // largest positive sum
    send_pixel(16'h7FFF);                   // large negative sum
    send_pixel(16'h0000);                   // zero sum counts as set
    send_word(beat_word(16'h7FFF));         // reload between beats of one pixel
    send_word(coef_word(8, 16'h7FFF));
    repeat (BeatsPerPixel - 1) send_word(beat_word(16'h0001));
    send_word(coef_word(31, 16'h0001));
    send_pixel(16'h0001);
    wait_for_results();

    // Random phases, each under a different box and fill setting.
    program_box(8'd0, 8'd160, 8'd0, 8'd160, 8'd0);
    run_random(PhaseWords, -1);
    program_box(8'd100, 8'd20, 8'd0, 8'd160, 8'd255);       // empty column range
    run_random(PhaseWords, -1);
    program_box(CfgW'($urandom_range(80)), CfgW'($urandom_range(160, 80)),
                CfgW'($urandom_range(2)), CfgW'($urandom_range(3)),
                CfgW'($urandom_range(255)));
    run_random(PhaseWords, PhaseWords / 2);
    program_box(8'd0, 8'd0, 8'd1, 8'd1, CfgW'($urandom_range(255)));
    run_random(PhaseWords, -1);
    program_box(8'd159, 8'd160, 8'd0, 8'd160, CfgW'($urandom_range(255)));
    run_random(PhaseWords, -1);
    program_box(CfgW'($urandom_range(160)), CfgW'($urandom_range(160)),
                CfgW'($urandom_range(160)), CfgW'($urandom_range(160)),
                CfgW'($urandom_range(255)));
    run_random(PhaseWords, -1);

    // Long stretch flat out on both sides, no idling at all.
    program_box(8'd40, 8'd120, 8'd0, 8'd160, 8'hA5);
    idle_on = 1'b0;
    repeat (FlatPixels) send_random_pixel();
    idle_on = 1'b1;
    wait_for_results();

    mask_check.flush_leftovers();
    if (mask_check.mismatch_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Hard stop well past the slowest correct run.
  initial begin : watchdog
    #10_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

### filelist.f
hw/rtl/smdp_pkg.sv
hw/rtl/smdp_lane.sv
hw/rtl/smdp_merge.sv
hw/rtl/seg_mask_dot_product_threshold.sv
bench/seg_mask_dot_product_threshold_tb.sv
